FILE: hw/rtl/c3cn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c3cn_pkg;

    // Configuration register file.
    localparam int CFG_DW   = 24;
    localparam int IDX_W    = 3;
    localparam int SIZE_W   = 11;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_KTOP   = 3'd2,
        CFG_KMID   = 3'd3,
        CFG_KBOT   = 3'd4
    } t_cfg_idx;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd1024;
    localparam logic [CFG_DW-1:0] KTOP_RST   = 24'd0;
    localparam logic [CFG_DW-1:0] KMID_RST   = 24'd256;
    localparam logic [CFG_DW-1:0] KBOT_RST   = 24'd0;

    // Request kinds on the input channel.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Row-slot address width: the pixel store has 2**ROW_SLOT_W rows, addressed by
    // a row count that runs on across frames, modulo the number of rows.
    localparam int ROW_SLOT_W = 3;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

endpackage
`default_nettype wire

FILE: hw/rtl/c3cn_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface c3cn_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, cmd, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, cmd, red_in, green_in, blue_in, alpha_in, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/c3cn_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface c3cn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_of_frame;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, last_of_frame,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_of_frame,
                    output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/c3cn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module c3cn_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] i_h,
    input  logic                    i_valid,
    input  logic                    i_cmd,
    input  c3cn_pkg::t_pixel        i_pixel,
    output logic                    o_ready,
    output logic                    o_wr_en,
    output logic [c3cn_pkg::ROW_SLOT_W+$clog2(MAX_WIDTH)-1:0] o_wr_addr,
    output c3cn_pkg::t_pixel        o_wr_data,
    output logic                    o_push,
    output logic [c3cn_pkg::ROW_SLOT_W+$clog2(MAX_HEIGHT+1)+$clog2(MAX_WIDTH):0] o_job,
    input  logic                    i_full
);
    import c3cn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int DW = $clog2(MAX_WIDTH + 3);

    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [CW-1:0] r_out_col, n_out_col;
    // Pixels received but not yet turned into an output request.
    logic [DW-1:0] r_pend, n_pend;
    // Store row slot of row 0 of the current frame; the next frame continues
    // after the last row so that its writes never hit rows still being read.
    logic [ROW_SLOT_W-1:0] r_base, n_base;

    logic accept;
    logic frame_in;
    logic last;
    logic emit;
    logic pix_in;
    logic [ROW_SLOT_W-1:0] wr_slot;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign frame_in  = (r_in_row >= i_h);
    assign last      = (r_out_row == i_h - RW'(1)) && (WW'(r_out_col) == i_w - WW'(1));
    assign wr_slot   = r_base + ROW_SLOT_W'(r_in_row);
    assign o_wr_addr = {wr_slot, r_in_col};
    assign o_wr_data = i_pixel;
    assign o_wr_en   = pix_in;
    assign o_push    = emit;
    assign o_job     = {r_base, r_out_row, r_out_col, last};

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_pend    = r_pend;
        n_base    = r_base;
        emit      = 1'b0;
        pix_in    = 1'b0;
        if (accept) begin
            if (i_cmd == CMD_FLUSH) begin
                emit = frame_in;
            end else if (!frame_in) begin
                pix_in = 1'b1;
                if (WW'(r_in_col) + WW'(1) >= i_w) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + RW'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
                // The window around the oldest pending output is complete.
                emit = (r_pend >= DW'(i_w) + DW'(1));
            end
        end
        n_pend = r_pend + DW'(pix_in) - DW'(emit);
        if (emit) begin
            if (last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
                n_pend    = '0;
                n_base    = r_base + ROW_SLOT_W'(i_h);
            end else if (WW'(r_out_col) + WW'(1) >= i_w) begin
                n_out_col = '0;
                n_out_row = r_out_row + RW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
        if (i_restart) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
            n_pend    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pend    <= '0;
            r_base    <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_pend    <= n_pend;
            r_base    <= n_base;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/c3cn_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
module c3cn_jobq #(
    parameter int JW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [JW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [JW-1:0] o_data
);
    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [JW-1:0]   r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CNTW'(i_push) - CNTW'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request queue read while empty");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && !i_pop) |=> $stable(r_cnt))
        else $error("request queue count moved without traffic");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/c3cn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module c3cn_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [c3cn_pkg::ROW_SLOT_W+$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  c3cn_pkg::t_pixel        i_wr_data,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] i_h,
    input  logic [c3cn_pkg::CFG_DW-1:0]     i_k_top,
    input  logic [c3cn_pkg::CFG_DW-1:0]     i_k_mid,
    input  logic [c3cn_pkg::CFG_DW-1:0]     i_k_bot,
    input  logic                    i_job_valid,
    input  logic [c3cn_pkg::ROW_SLOT_W+$clog2(MAX_HEIGHT+1)+$clog2(MAX_WIDTH):0] i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic [7:0]              o_alpha,
    output logic                    o_last
);
    import c3cn_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = ROW_SLOT_W + CW;
    localparam int DEPTH = 2 ** AW;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_LASTACC, S_PREP, S_DIV, S_OUT
    } t_state;

    t_pixel r_mem [DEPTH];
    t_pixel r_rd_data;

    t_state r_state;
    logic [ROW_SLOT_W-1:0] r_base;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic                r_last;
    logic [1:0]          r_i;
    logic [1:0]          r_j;
    logic                r_acc_en;
    logic                r_is_ctr;
    logic signed [7:0]   r_wt;
    logic signed [19:0]  r_sum [3];
    logic signed [11:0]  r_ks;
    logic [7:0]          r_ctr_alpha;
    logic [18:0]         r_rem [3];
    logic [18:0]         r_dv;
    logic [7:0]          r_q [3];
    logic [2:0]          r_zero;
    logic [2:0]          r_sat;
    logic [2:0]          r_step;
    logic                r_ov;
    logic [7:0]          r_res [3];
    logic [7:0]          r_alpha;
    logic                r_out_last;

    logic [RW-1:0]       rr;
    logic [CW-1:0]       cc;
    logic [ROW_SLOT_W-1:0] rd_slot;
    logic [AW-1:0]       rd_addr;
    logic [CFG_DW-1:0]   krow;
    logic signed [7:0]   wt;
    logic [7:0]          chan [3];
    logic signed [16:0]  prod [3];
    logic signed [11:0]  ks0;
    logic [10:0]         mag_d;
    logic                neg_d;
    logic [19:0]         abs_s [3];
    logic [2:0]          neg_s;
    logic                out_free;

    // Neighbor coordinates, clamped to the frame edge, and the neighbor's kernel weight.
    always_comb begin
        case (r_i)
            2'd0:    rr = (r_row == '0) ? r_row : r_row - RW'(1);
            2'd2:    rr = (r_row == i_h - RW'(1)) ? r_row : r_row + RW'(1);
            default: rr = r_row;
        endcase
        case (r_j)
            2'd0:    cc = (r_col == '0) ? r_col : r_col - CW'(1);
            2'd2:    cc = (WW'(r_col) == i_w - WW'(1)) ? r_col : r_col + CW'(1);
            default: cc = r_col;
        endcase
        case (r_i)
            2'd0:    krow = i_k_top;
            2'd2:    krow = i_k_bot;
            default: krow = i_k_mid;
        endcase
        case (r_j)
            2'd0:    wt = $signed(krow[7:0]);
            2'd2:    wt = $signed(krow[23:16]);
            default: wt = $signed(krow[15:8]);
        endcase
    end

    assign rd_slot = r_base + ROW_SLOT_W'(rr);
    assign rd_addr = {rd_slot, cc};
    assign chan[0] = r_rd_data.red;
    assign chan[1] = r_rd_data.green;
    assign chan[2] = r_rd_data.blue;

    always_comb begin
        ks0   = (r_ks == '0) ? 12'sd1 : r_ks;
        neg_d = ks0[11];
        mag_d = neg_d ? 11'(-ks0) : ks0[10:0];
        for (int c = 0; c < 3; c++) begin
            prod[c]  = r_wt * $signed({1'b0, chan[c]});
            neg_s[c] = r_sum[c][19];
            abs_s[c] = neg_s[c] ? 20'(-r_sum[c]) : 20'(r_sum[c]);
        end
    end

    assign out_free = !r_ov || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_job_valid;
    assign o_valid  = r_ov;
    assign o_red    = r_res[0];
    assign o_green  = r_res[1];
    assign o_blue   = r_res[2];
    assign o_alpha  = r_alpha;
    assign o_last   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc_en <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_acc_en <= (r_state == S_READ);
            if (r_ov && i_ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            // Read data of the previous neighbor arrives in the cycle after its address.
            if (r_acc_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_sum[c] + 20'(prod[c]);
                end
                if (r_is_ctr) begin
                    r_ctr_alpha <= r_rd_data.alpha;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        {r_base, r_row, r_col, r_last} <= i_job;
                        r_i     <= 2'd0;
                        r_j     <= 2'd0;
                        r_ks    <= '0;
                        for (int c = 0; c < 3; c++) begin
                            r_sum[c] <= '0;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_wt     <= wt;
                    r_is_ctr <= (r_i == 2'd1) && (r_j == 2'd1);
                    r_ks     <= r_ks + 12'(wt);
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= r_i + 2'd1;
                        if (r_i == 2'd2) begin
                            r_state <= S_LASTACC;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_LASTACC: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_dv <= {1'b0, mag_d, 7'b0};
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c]  <= abs_s[c][18:0];
                        r_q[c]    <= '0;
                        r_zero[c] <= (neg_s[c] != neg_d);
                        r_sat[c]  <= (abs_s[c] >= {1'b0, mag_d, 8'b0});
                    end
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // One restoring step per cycle; saturation already covers 256 and up.
                    for (int c = 0; c < 3; c++) begin
                        if (r_rem[c] >= r_dv) begin
                            r_rem[c] <= r_rem[c] - r_dv;
                            r_q[c]   <= {r_q[c][6:0], 1'b1};
                        end else begin
                            r_q[c]   <= {r_q[c][6:0], 1'b0};
                        end
                    end
                    r_dv   <= r_dv >> 1;
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        for (int c = 0; c < 3; c++) begin
                            r_res[c] <= r_zero[c] ? 8'd0 : (r_sat[c] ? 8'd255 : r_q[c]);
                        end
                        r_alpha    <= r_ctr_alpha;
                        r_out_last <= r_last;
                        r_ov       <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/conv3x3_clamped_normalized.sv
`timescale 1ns / 1ps
`default_nettype none
// 3x3 convolution of the RGB channels of an RGBA raster stream with clamped
// borders and division by the kernel sum; alpha is the centre pixel's alpha.
// Input channel i_pix: each request is a pixel (cmd = 0) or a flush (cmd = 1).
// Output channel o_pix: one filtered pixel per output request, last_of_frame
// set on the final pixel of a frame. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
// block is idle, which the block does not enforce. A write of the width or
// height restarts the frame. Output pixel k becomes computable when input
// pixel k+width+1 arrives; the rest of a frame is drained by flush requests.
// Pixels that complete no window are taken one per cycle while the request
// queue is not full. In the back end each output passes through nine reads
// of the pixel store (one write port, one read port), one last accumulate,
// one setup step, an eight-step divider and the output register. A two-entry
// request queue lets the input run ahead of the back end by up to two outputs.
// Reset returns the registers to an identity kernel at 1024x1024 and empties
// the counters, queue and output register; the pixel store is not cleared.
// When the receiver stalls the result holds in the output register, the back
// end stops, the queue fills and then i_pix.ready drops.
module conv3x3_clamped_normalized #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [c3cn_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [c3cn_pkg::CFG_DW-1:0]   i_cfg_data,
    c3cn_in_if.sink                       i_pix,
    c3cn_out_if.source                    o_pix
);
    import c3cn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = ROW_SLOT_W + CW;
    localparam int JW = ROW_SLOT_W + RW + CW + 1;

    logic [SIZE_W-1:0] r_img_w;
    logic [SIZE_W-1:0] r_img_h;
    logic [CFG_DW-1:0] r_k_top;
    logic [CFG_DW-1:0] r_k_mid;
    logic [CFG_DW-1:0] r_k_bot;

    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [31:0]   w32;
    logic [31:0]   h32;
    logic          restart;

    t_pixel        in_pixel;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_pixel        wr_data;
    logic          push;
    logic [JW-1:0] push_job;
    logic          q_full;
    logic          pop;
    logic          q_valid;
    logic [JW-1:0] q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RST;
            r_img_h <= HEIGHT_RST;
            r_k_top <= KTOP_RST;
            r_k_mid <= KMID_RST;
            r_k_bot <= KBOT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_img_w <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_img_h <= i_cfg_data[SIZE_W-1:0];
                CFG_KTOP:   r_k_top <= i_cfg_data;
                CFG_KMID:   r_k_mid <= i_cfg_data;
                CFG_KBOT:   r_k_bot <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && ((i_cfg_idx == CFG_WIDTH) || (i_cfg_idx == CFG_HEIGHT));

    // A size of zero counts as one, a size above the maximum as the maximum.
    always_comb begin
        w32 = 32'(r_img_w);
        h32 = 32'(r_img_h);
        if (w32 == 32'd0) begin
            w_eff = WW'(1);
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w32);
        end
        if (h32 == 32'd0) begin
            h_eff = RW'(1);
        end else if (h32 > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(h32);
        end
    end

    assign in_pixel = '{alpha: i_pix.alpha_in, blue: i_pix.blue_in,
                        green: i_pix.green_in, red: i_pix.red_in};

    c3cn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_w       (w_eff),
        .i_h       (h_eff),
        .i_valid   (i_pix.valid),
        .i_cmd     (i_pix.cmd),
        .i_pixel   (in_pixel),
        .o_ready   (i_pix.ready),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (push),
        .o_job     (push_job),
        .i_full    (q_full)
    );

    c3cn_jobq #(
        .JW (JW)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    c3cn_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_w         (w_eff),
        .i_h         (h_eff),
        .i_k_top     (r_k_top),
        .i_k_mid     (r_k_mid),
        .i_k_bot     (r_k_bot),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (o_pix.valid),
        .i_ready     (o_pix.ready),
        .o_red       (o_pix.red_out),
        .o_green     (o_pix.green_out),
        .o_blue      (o_pix.blue_out),
        .o_alpha     (o_pix.alpha_out),
        .o_last      (o_pix.last_of_frame)
    );

endmodule
`default_nettype wire
